[rtl/swmt_pkg.sv]
// Shared types and constants for the sliding-window maximum filter.
`timescale 1ns / 1ps
package swmt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned TagW   = 24;
  localparam int unsigned LenW   = 7;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic        [TagW-1:0]   tag;
  } sample_t;

  typedef struct packed {
    logic    vld;
    sample_t smp;
  } token_t;

endpackage

[rtl/swmt_cell.sv]
// One window cell: holds a sample of fixed age and folds the passing search token.
`timescale 1ns / 1ps
module swmt_cell #(
  parameter int unsigned Index  = 0,
  parameter int unsigned CountW = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  swmt_pkg::sample_t   sample_i,
  output swmt_pkg::sample_t   sample_o,
  input  logic                start_i,
  input  logic [CountW-1:0]   count_i,
  input  logic                hold_i,
  input  swmt_pkg::token_t    tok_i,
  output swmt_pkg::token_t    tok_o
);

  swmt_pkg::sample_t sample_q;
  swmt_pkg::token_t  tok_d, tok_q;
  logic              inject;

  assign inject = start_i && (count_i == CountW'(Index + 1));

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  // Token arrives from the older neighbour; the earlier sample keeps ties.
  always_comb begin
    tok_d     = tok_q;
    tok_d.vld = 1'b0;
    if (tok_i.vld) begin
      tok_d.vld = 1'b1;
      if ($signed(sample_q.value) > $signed(tok_i.smp.value)) begin
        tok_d.smp = sample_q;
      end else begin
        tok_d.smp = tok_i.smp;
      end
    end else if (inject) begin
      tok_d.vld = 1'b1;
      tok_d.smp = sample_q;
    end else if (hold_i && tok_q.vld) begin
      tok_d.vld = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign sample_o = sample_q;
  assign tok_o    = tok_q;

endmodule

[rtl/sliding_window_max_with_tag.sv]
// Top level of the streaming sliding-window maximum filter with tag.
`timescale 1ns / 1ps
// Running maximum over the last window_length samples of a line, returning
// the winning sample's tag (earliest sample on ties); line_start empties the
// window. Samples sit in a shift chain of MAX_WINDOW cells, newest in cell 0.
// After a transaction is taken, a search token is launched at the oldest
// covered cell and walks one cell per cycle towards cell 0; the covered
// cells number min(window_length, samples seen in the line). No new
// sample is taken while the token walks. A finished result waits in the
// output register while the next sample is taken.
module sliding_window_max_with_tag #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swmt_pkg::LenW-1:0]          cfg_window_length_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [swmt_pkg::ValueW-1:0] sample_value_i,
  input  logic [swmt_pkg::TagW-1:0]          sample_tag_i,
  input  logic                               line_start_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [swmt_pkg::ValueW-1:0] max_value_o,
  output logic [swmt_pkg::TagW-1:0]          max_tag_o
);

  localparam int unsigned CountW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LW     = (CountW > swmt_pkg::LenW) ? CountW : swmt_pkg::LenW;

  logic [swmt_pkg::LenW-1:0] len_q;
  logic [CountW-1:0]         fill_q, fill_d, fill_base;
  logic [CountW-1:0]         count_q, count_d;
  logic [LW-1:0]             len_ext, eff_len, fill_ext;
  logic                      start_q, busy_q, out_valid_q;
  logic                      accept, out_free, finish;
  swmt_pkg::sample_t         out_q;
  swmt_pkg::sample_t         sample_w [MAX_WINDOW];
  swmt_pkg::token_t          tok_w [MAX_WINDOW+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= swmt_pkg::LenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_window_length_i;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = tok_w[0].vld && out_free;
  assign in_stall_o = busy_q && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fill_base = line_start_i ? '0 : fill_q;
    fill_d    = (fill_base == CountW'(MAX_WINDOW)) ? fill_base : fill_base + CountW'(1);
    len_ext   = LW'(len_q);
    if (len_ext == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > LW'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = len_ext;
    end
    fill_ext = LW'(fill_d);
    count_d  = (eff_len < fill_ext) ? CountW'(eff_len) : fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      start_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        fill_q <= fill_d;
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_q <= count_d;
    end
    if (finish) begin
      out_q <= tok_w[0].smp;
    end
  end

  assign sample_w[0]       = '{value: sample_value_i, tag: sample_tag_i};
  assign tok_w[MAX_WINDOW] = '0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i < MAX_WINDOW - 1) begin : g_mid
      swmt_cell #(
        .Index  (i),
        .CountW (CountW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (accept),
        .sample_i (sample_w[i]),
        .sample_o (sample_w[i+1]),
        .start_i  (start_q),
        .count_i  (count_q),
        .hold_i   ((i == 0) ? !out_free : 1'b0),
        .tok_i    (tok_w[i+1]),
        .tok_o    (tok_w[i])
      );
    end else begin : g_last
      swmt_cell #(
        .Index  (i),
        .CountW (CountW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (accept),
        .sample_i (sample_w[i]),
        .sample_o (),
        .start_i  (start_q),
        .count_i  (count_q),
        .hold_i   ((i == 0) ? !out_free : 1'b0),
        .tok_i    (tok_w[i+1]),
        .tok_o    (tok_w[i])
      );
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = out_q.value;
  assign max_tag_o   = out_q.tag;

endmodule
